[rtl/core/qsdf_pkg.sv]
// Shared types and opcodes for the queue set-difference filter.
package qsdf_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;

    typedef logic [OPCODE_W-1:0]       t_opcode;
    typedef logic signed [VALUE_W-1:0] t_value;

    // Item opcodes
    localparam t_opcode OP_MAIN    = 2'd0;
    localparam t_opcode OP_REMOVAL = 2'd1;
    localparam t_opcode OP_RUN     = 2'd2;

endpackage

[rtl/core/qsdf_in_if.sv]
// Input channel: opcode and value with valid/ready handshake.
interface qsdf_in_if import qsdf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_value  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

[rtl/core/qsdf_out_if.sv]
// Result channel: kept value, last marker and overflow flag with valid/ready handshake.
interface qsdf_out_if import qsdf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value kept_value;
    logic   last;
    logic   overflow;

    modport source (output valid, output kept_value, output last, output overflow, input ready);
    modport sink   (input valid, input kept_value, input last, input overflow, output ready);
endinterface

[rtl/core/queue_set_difference_filter.sv]
// Queue set-difference filter: main and removal queues, filtered on a run item.
// Append items are accepted while idle, and the block stays ready for the next item.
// A run compares each main entry against the removal entries in order up to the first
// match, then closes; one shared 32-bit comparator does every compare.
// A result leaves one element behind the scan, so last can be marked; output stalls hold the scan.
// Synchronous active-low reset empties both queues and clears the overflow flag.
module queue_set_difference_filter import qsdf_pkg::*; #(
    parameter int MAIN_DEPTH    = 32,
    parameter int REMOVAL_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qsdf_in_if.sink          i_in,
    qsdf_out_if.source       o_out
);

    localparam int MAIN_AW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int MAIN_CW = $clog2(MAIN_DEPTH + 1);
    localparam int REM_AW  = (REMOVAL_DEPTH > 1) ? $clog2(REMOVAL_DEPTH) : 1;
    localparam int REM_CW  = $clog2(REMOVAL_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [MAIN_AW-1:0] r_i, n_i;
    logic [REM_AW-1:0]  r_j, n_j;
    logic               r_pend_valid, n_pend_valid;
    t_value             r_pend_value, n_pend_value;
    logic               r_ovf, n_ovf;
    logic               r_out_valid;
    t_value             r_out_value;
    logic               r_out_last;
    logic               r_out_ovf;

    logic               accept;
    logic               push_main, push_rem;
    logic               q_clear;
    logic               load_out, load_last;
    logic               out_free;
    logic               hit, scan_end, kept;
    t_value             main_data, rem_data;
    logic [MAIN_CW-1:0] main_count;
    logic [REM_CW-1:0]  rem_count;
    logic               main_full, rem_full;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign push_main  = accept && (i_in.opcode == OP_MAIN);
    assign push_rem   = accept && (i_in.opcode == OP_REMOVAL);
    assign out_free   = !r_out_valid || o_out.ready;

    qsdf_queue #(.DEPTH(MAIN_DEPTH)) u_main (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_main),
        .i_data    (i_in.value),
        .i_clear   (q_clear),
        .i_rd_addr (n_i),
        .o_rd_data (main_data),
        .o_count   (main_count),
        .o_full    (main_full)
    );

    qsdf_queue #(.DEPTH(REMOVAL_DEPTH)) u_removal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_rem),
        .i_data    (i_in.value),
        .i_clear   (q_clear),
        .i_rd_addr (n_j),
        .o_rd_data (rem_data),
        .o_count   (rem_count),
        .o_full    (rem_full)
    );

    // Shared comparator: current main entry against current removal entry
    assign hit      = (rem_count != '0) && (main_data == rem_data);
    assign scan_end = hit || (rem_count == '0) || ((REM_CW'(r_j) + REM_CW'(1)) == rem_count);
    assign kept     = !hit;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_ovf        = r_ovf;
        q_clear      = 1'b0;
        load_out     = 1'b0;
        load_last    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if ((push_main && main_full) || (push_rem && rem_full)) begin
                    n_ovf = 1'b1;
                end
                if (accept && (i_in.opcode == OP_RUN)) begin
                    n_i          = '0;
                    n_j          = '0;
                    n_pend_valid = 1'b0;
                    n_state      = (main_count == '0) ? S_FLUSH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_end) begin
                    n_j = r_j + REM_AW'(1);
                end else if (!(kept && r_pend_valid && !out_free)) begin
                    // entry decided: if kept, the older pending value goes out and this one waits
                    if (kept) begin
                        load_out     = r_pend_valid;
                        n_pend_valid = 1'b1;
                        n_pend_value = main_data;
                    end
                    n_j = '0;
                    if ((MAIN_CW'(r_i) + MAIN_CW'(1)) == main_count) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_i = r_i + MAIN_AW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    load_out     = r_pend_valid;
                    load_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_ovf        = 1'b0;
                    q_clear      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_j          <= n_j;
            r_pend_valid <= n_pend_valid;
            r_ovf        <= n_ovf;
        end
    end

    // Pending kept value
    always_ff @(posedge i_clk) begin
        r_pend_value <= n_pend_value;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= r_pend_value;
            r_out_last  <= load_last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kept_value = r_out_value;
    assign o_out.last       = r_out_last;
    assign o_out.overflow   = r_out_ovf;

endmodule

[rtl/core/qsdf_queue.sv]
// Append-only queue store with fill count and one registered read port.
module qsdf_queue import qsdf_pkg::*; #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_value        i_data,
    input  logic          i_clear,
    input  logic [AW-1:0] i_rd_addr,
    output t_value        o_rd_data,
    output logic [CW-1:0] o_count,
    output logic          o_full
);

    t_value        r_mem [DEPTH];
    logic [CW-1:0] r_count;
    t_value        r_rd_data;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_rd_data = r_rd_data;

    // Fill count: appends below full, run end empties the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (i_push && !o_full) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Storage: write at the tail, registered read
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_count[AW-1:0]] <= i_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

endmodule

[rtl/core/qsdf_checker.sv]
// Port-level checks for the queue set-difference filter, bound to the top level.
module qsdf_checker import qsdf_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input t_opcode i_in_opcode,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_value  i_out_value,
    input logic    i_out_last,
    input logic    i_out_overflow
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_last)
            && $stable(i_out_overflow))
        else $error("result changed while stalled");

    // Results only appear while a run keeps the input closed
    a_out_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared outside a run");

    // A result ahead of the last one means the run is still going
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input open while run results remain");

    // An accepted run closes the input
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == OP_RUN) |=> !i_in_ready)
        else $error("input open after run item");

endmodule

bind queue_set_difference_filter qsdf_checker u_qsdf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_opcode    (i_in.opcode),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_value    (o_out.kept_value),
    .i_out_last     (o_out.last),
    .i_out_overflow (o_out.overflow)
);
